[rtl/tqz_pkg.sv]
// Shared constants and types for the top-k magnitude ternary quantizer.
package tqz_pkg;

  localparam int SAMPLE_W    = 32;  // signed Q16.16 sample
  localparam int KEEP_W      = 7;   // keep_count register width
  localparam int DEF_MAX_DIM = 64;  // default vector capacity
  localparam int OUT_DATA_W  = 8;   // plus/minus flags padded to a byte

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,   // taking samples into the store
    ST_FETCH,  // read the element being ranked
    ST_HOLD,   // latch it, start the scan at index zero
    ST_SCAN,   // one comparison per cycle over the vector
    ST_PUSH    // hand the result to the output register
  } tqz_state_t;

endpackage

[rtl/tqz_sample_mem.sv]
// Sample store: one write port, one registered read port.
module tqz_sample_mem #(
  parameter int MAX_DIM = tqz_pkg::DEF_MAX_DIM,
  parameter int IDX_W   = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [tqz_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [tqz_pkg::SAMPLE_W-1:0] rd_data
);
  import tqz_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_DIM];

  // write on sample request
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/tqz_rank_cmp.sv]
// Shared rank comparator: does the candidate rank ahead of the current element?
module tqz_rank_cmp #(
  parameter int IDX_W = 6
) (
  input  logic [tqz_pkg::SAMPLE_W-1:0] cur_raw,
  input  logic [IDX_W-1:0]             cur_idx,
  input  logic [tqz_pkg::SAMPLE_W-1:0] cand_raw,
  input  logic [IDX_W-1:0]             cand_idx,
  output logic                         ahead
);
  import tqz_pkg::*;

  logic [SAMPLE_W-1:0] cur_mag;
  logic [SAMPLE_W-1:0] cand_mag;

  // exact absolute value; the most negative sample maps to 2^31
  assign cur_mag  = cur_raw[SAMPLE_W-1]  ? (~cur_raw + SAMPLE_W'(1))  : cur_raw;
  assign cand_mag = cand_raw[SAMPLE_W-1] ? (~cand_raw + SAMPLE_W'(1)) : cand_raw;

  // larger magnitude first, ties to the lower index
  assign ahead = (cand_mag > cur_mag) || ((cand_mag == cur_mag) && (cand_idx < cur_idx));

endmodule

[rtl/top_magnitude_ternary_quantizer_unit.sv]
// Top level: sample loading, rank sequencer and result output register.
// Sequence: after the final sample each element is ranked in turn through
//   fetch, hold, dim compares and push.
// Throughput: one vector at a time; push waits out m_tready stalls; s_tready is
//   low from the final sample until the last result is in the output register.
// Reset (rst, synchronous): clears state, load count, keep_count and output valid only.
module top_magnitude_ternary_quantizer_unit #(
  parameter int MAX_DIM = tqz_pkg::DEF_MAX_DIM
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write: keep_count
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tqz_pkg::KEEP_W-1:0]     cfg_data,
  // sample stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tqz_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  input  logic                           s_tlast,   // last_sample
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tqz_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] plus_flag, [1] minus_flag, rest 0
  output logic                           m_tlast    // last_result
);
  import tqz_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  tqz_state_t state, state_next;

  logic [KEEP_W-1:0]   keep_count;
  logic [CNT_W-1:0]    load_cnt, load_cnt_next;
  logic [CNT_W-1:0]    dim, dim_next;
  logic [KEEP_W-1:0]   keep_lat, keep_lat_next;
  logic [IDX_W-1:0]    cur_idx, cur_idx_next;
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic [IDX_W-1:0]    ahead_cnt, ahead_cnt_next;
  logic [SAMPLE_W-1:0] cur_raw, cur_raw_next;
  logic                kept, kept_next;
  logic                out_valid_next;
  logic [OUT_DATA_W-1:0] out_data_next;
  logic                out_last_next;

  logic                s_accept;
  logic                out_free;
  logic [IDX_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                cmp_ahead;
  logic [IDX_W-1:0]    ahead_sum;
  logic                scan_done;
  logic                elem_last;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_LOAD);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // keep_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  tqz_sample_mem #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (s_accept),
    .wr_addr (load_cnt[IDX_W-1:0]),
    .wr_data (s_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tqz_rank_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .cur_raw  (cur_raw),
    .cur_idx  (cur_idx),
    .cand_raw (rd_data),
    .cand_idx (cmp_idx),
    .ahead    (cmp_ahead)
  );

  assign ahead_sum = ahead_cnt + IDX_W'(cmp_ahead);
  assign scan_done = (CNT_W'(cmp_idx) == dim - CNT_W'(1));
  assign elem_last = (CNT_W'(cur_idx) == dim - CNT_W'(1));

  // sequencer: next state and datapath
  always_comb begin
    state_next     = state;
    load_cnt_next  = load_cnt;
    dim_next       = dim;
    keep_lat_next  = keep_lat;
    cur_idx_next   = cur_idx;
    cmp_idx_next   = cmp_idx;
    ahead_cnt_next = ahead_cnt;
    cur_raw_next   = cur_raw;
    kept_next      = kept;
    rd_addr        = cur_idx;
    out_valid_next = m_tvalid && !m_tready;
    out_data_next  = m_tdata;
    out_last_next  = m_tlast;

    unique case (state)
      ST_LOAD: begin
        if (s_accept) begin
          load_cnt_next = load_cnt + CNT_W'(1);
          // a full store ends the vector too
          if (s_tlast || (load_cnt == CNT_W'(MAX_DIM - 1))) begin
            dim_next      = load_cnt + CNT_W'(1);
            keep_lat_next = keep_count;
            load_cnt_next = '0;
            cur_idx_next  = '0;
            state_next    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        rd_addr    = cur_idx;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        cur_raw_next   = rd_data;
        rd_addr        = '0;
        cmp_idx_next   = '0;
        ahead_cnt_next = '0;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        rd_addr        = cmp_idx + IDX_W'(1);
        cmp_idx_next   = cmp_idx + IDX_W'(1);
        ahead_cnt_next = ahead_sum;
        if (scan_done) begin
          // ahead count stays below dim, so no clamp of keep is needed
          kept_next  = (KEEP_W'(ahead_sum) < keep_lat);
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '0;
          out_data_next[0] = kept && !cur_raw[SAMPLE_W-1];
          out_data_next[1] = kept && cur_raw[SAMPLE_W-1];
          out_last_next  = elem_last;
          if (elem_last) begin
            state_next = ST_LOAD;
          end else begin
            cur_idx_next = cur_idx + IDX_W'(1);
            state_next   = ST_FETCH;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      load_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      load_cnt <= load_cnt_next;
      m_tvalid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dim       <= dim_next;
    keep_lat  <= keep_lat_next;
    cur_idx   <= cur_idx_next;
    cmp_idx   <= cmp_idx_next;
    ahead_cnt <= ahead_cnt_next;
    cur_raw   <= cur_raw_next;
    kept      <= kept_next;
    m_tdata   <= out_data_next;
    m_tlast   <= out_last_next;
  end

endmodule

[rtl/tqz_checker.sv]
// Port-level checks for the quantizer, bound to the top level.
module tqz_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tqz_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // an element is never both plus and minus, padding stays zero
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[7:2] == '0))
    else $error("bad result flags");

  // taking the final sample starts ranking and drops s_tready
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("sample request taken during ranking");

  // reset leaves the block ready with no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("bad state after reset");

endmodule

bind top_magnitude_ternary_quantizer_unit tqz_checker u_tqz_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
